### rtl/fip_pkg.sv
// Shared types and constants for the float_integer_power block.
// No dependencies; used by fip_fpu, fip_ctrl and the top level.
package fip_pkg;

   // exponent width taken from the input field
   localparam int EXP_BITS = 16;

   // double-precision layout
   localparam int MANT_W  = 53;
   localparam int PROD_W  = 2 * MANT_W;
   localparam int CHUNK_W = 14;
   localparam int Z_W     = 14;

   localparam logic [63:0] ONE_BITS     = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] NEG_ONE_BITS = 64'hBFF0_0000_0000_0000;
   localparam logic [63:0] DEFAULT_NAN  = 64'hFFF8_0000_0000_0000;
   localparam logic [63:0] QUIET_BIT    = 64'h0008_0000_0000_0000;
   localparam logic [10:0] EXP_MAX      = 11'h7FF;

   // sequencer states
   typedef enum logic [1:0] {
      C_IDLE,
      C_MUL,
      C_DIV
   } ctrl_state_type;

   // arithmetic unit states
   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL,
      F_DNORM,
      F_DIV,
      F_NORM,
      F_ALIGN,
      F_ROUND
   } fpu_state_type;

   // operation request to the arithmetic unit
   typedef struct packed {
      logic        start;
      logic        is_div;   // 1: 1.0 / a, 0: a * b
      logic [63:0] a;
      logic [63:0] b;
   } fpu_req_type;

   // completion from the arithmetic unit
   typedef struct packed {
      logic        done;
      logic [63:0] bits;
   } fpu_rsp_type;

endpackage

### rtl/float_integer_power.sv
// Top level of float_integer_power: IEEE double base raised to a signed integer exponent.
// Depends on fip_pkg, fip_ctrl and fip_fpu.
//
// Usage:
//   An item is taken when start is high and busy is low; req_base_bits and
//   req_power_exponent are sampled at that edge. Exactly one result follows:
//   rsp_result_bits is valid for the single cycle in which rsp_valid is high,
//   and the receiver must take it then; there is no back-pressure.
//   Special cases (zero exponent, exponent one, zero base with a
//   positive exponent) answer in the cycle after the accept. Otherwise the
//   result costs one pass of the shared double unit per multiplication,
//   up to |exponent| passes, plus a reciprocal pass for a negative
//   exponent. A multiply pass for normal operands forms four 53x14 partial
//   products, then normalizes, aligns, rounds and hands off the result;
//   subnormals or underflow add bit-by-bit shifting. A zero, infinite or
//   NaN operand ends a pass from the operand check alone. The reciprocal
//   pass forms 56 quotient bits, one per cycle, after left-justifying a
//   subnormal product bit by bit.
//   The loop ends early once the product stops changing.
//   Items are handled one at a time: busy stays high until the result is
//   driven. Reset returns the sequencer and the unit to idle; no result
//   is pending after reset.
module float_integer_power (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_base_bits,
   input  logic [15:0] req_power_exponent,
   output logic        rsp_valid,
   output logic [63:0] rsp_result_bits
);

   fip_pkg::fpu_req_type fpu_req;
   fip_pkg::fpu_rsp_type fpu_rsp;

   fip_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .base_bits      (req_base_bits),
      .power_exponent (req_power_exponent),
      .fpu_rsp        (fpu_rsp),
      .fpu_req        (fpu_req),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_bits       (rsp_result_bits)
   );

   fip_fpu u_fpu (
      .clock (clock),
      .reset (reset),
      .req   (fpu_req),
      .rsp   (fpu_rsp)
   );

endmodule

### rtl/fip_fpu.sv
// Shared double-precision unit: multiply a*b or reciprocal 1/a, round to nearest even.
// Depends on fip_pkg. Multi-cycle: partial products, bit-serial divide, shift-one normalize.
module fip_fpu (
   input  logic                 clock,
   input  logic                 reset,
   input  fip_pkg::fpu_req_type req,
   output fip_pkg::fpu_rsp_type rsp
);

   fip_pkg::fpu_state_type state_ff, state_in;
   logic                              sign_ff, sign_in;
   logic signed [fip_pkg::Z_W-1:0]    z_ff, z_in;
   logic [fip_pkg::PROD_W-1:0]        p_ff, p_in;
   logic [fip_pkg::MANT_W-1:0]        ma_ff, ma_in;
   logic [fip_pkg::MANT_W-1:0]        mb_ff, mb_in;
   logic [fip_pkg::MANT_W:0]          rem_ff, rem_in;
   logic [5:0]                        cnt_ff, cnt_in;
   logic [63:0]                       res_ff, res_in;
   logic                              done_ff, done_in;

   // operand fields
   logic        sa, sb;
   logic [10:0] ea, eb;
   logic [51:0] fa, fb;
   logic        a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;

   // datapath pieces
   logic [55:0]                 mb_pad;
   logic [fip_pkg::CHUNK_W-1:0] chunk;
   logic [66:0]                 partial;
   logic [fip_pkg::PROD_W-1:0]  partial_sh;
   logic                        qbit;
   logic [fip_pkg::MANT_W:0]    rem_sub;
   logic [fip_pkg::MANT_W:0]    m_rnd, m_sum;
   logic                        g_bit, s_bit, up;
   logic signed [fip_pkg::Z_W-1:0] z_rnd;
   logic [52:0]                 mant_out;

   always_comb begin
      sa = req.a[63]; ea = req.a[62:52]; fa = req.a[51:0];
      sb = req.b[63]; eb = req.b[62:52]; fb = req.b[51:0];
      a_zero = (ea == 11'd0) && (fa == 52'd0);
      b_zero = (eb == 11'd0) && (fb == 52'd0);
      a_inf  = (ea == fip_pkg::EXP_MAX) && (fa == 52'd0);
      b_inf  = (eb == fip_pkg::EXP_MAX) && (fb == 52'd0);
      a_nan  = (ea == fip_pkg::EXP_MAX) && (fa != 52'd0);
      b_nan  = (eb == fip_pkg::EXP_MAX) && (fb != 52'd0);
   end

   // one 53x14 partial product per cycle
   always_comb begin
      mb_pad     = {3'b000, mb_ff};
      chunk      = mb_pad[cnt_ff[1:0]*fip_pkg::CHUNK_W +: fip_pkg::CHUNK_W];
      partial    = ma_ff * chunk;
      partial_sh = {39'd0, partial} << (cnt_ff[1:0] * fip_pkg::CHUNK_W);
   end

   // restoring divide step
   always_comb begin
      qbit    = (rem_ff >= {1'b0, mb_ff});
      rem_sub = qbit ? (rem_ff - {1'b0, mb_ff}) : rem_ff;
   end

   // rounding to nearest even
   always_comb begin
      m_rnd = {1'b0, p_ff[105:53]};
      g_bit = p_ff[52];
      s_bit = |p_ff[51:0];
      up    = g_bit & (s_bit | m_rnd[0]);
      m_sum = m_rnd + {{fip_pkg::MANT_W{1'b0}}, up};
      if (m_sum[53]) begin
         mant_out = m_sum[53:1];
         z_rnd    = z_ff + 14'sd1;
      end else begin
         mant_out = m_sum[52:0];
         z_rnd    = z_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fip_pkg::F_IDLE: begin
            if (req.start) begin
               if (!req.is_div) begin
                  if (!(a_nan || b_nan || a_inf || b_inf || a_zero || b_zero))
                     state_in = fip_pkg::F_MUL;
               end else if (!(a_nan || a_inf || a_zero)) begin
                  state_in = fip_pkg::F_DNORM;
               end
            end
         end
         fip_pkg::F_MUL:   if (cnt_ff[1:0] == 2'd3) state_in = fip_pkg::F_NORM;
         fip_pkg::F_DNORM: if (mb_ff[52]) state_in = fip_pkg::F_DIV;
         fip_pkg::F_DIV:   if (cnt_ff == 6'd55) state_in = fip_pkg::F_NORM;
         fip_pkg::F_NORM:  if (p_ff[105]) state_in = fip_pkg::F_ALIGN;
         fip_pkg::F_ALIGN: if (z_ff >= 14'sd1) state_in = fip_pkg::F_ROUND;
         fip_pkg::F_ROUND: state_in = fip_pkg::F_IDLE;
         default:          state_in = fip_pkg::F_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      sign_in = sign_ff;
      z_in    = z_ff;
      p_in    = p_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      res_in  = res_ff;
      done_in = 1'b0;
      case (state_ff)
         fip_pkg::F_IDLE: begin
            if (req.start) begin
               cnt_in = 6'd0;
               p_in   = '0;
               if (!req.is_div) begin
                  sign_in = sa ^ sb;
                  ma_in   = {ea != 11'd0, fa};
                  mb_in   = {eb != 11'd0, fb};
                  z_in    = fip_pkg::Z_W'(14'sd0
                          + $signed({3'b000, (ea == 11'd0) ? 11'd1 : ea})
                          + $signed({3'b000, (eb == 11'd0) ? 11'd1 : eb}) - 14'sd1022);
                  // specials, first NaN operand wins
                  if (a_nan) begin
                     res_in = req.a | fip_pkg::QUIET_BIT; done_in = 1'b1;
                  end else if (b_nan) begin
                     res_in = req.b | fip_pkg::QUIET_BIT; done_in = 1'b1;
                  end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                     res_in = fip_pkg::DEFAULT_NAN; done_in = 1'b1;
                  end else if (a_inf || b_inf) begin
                     res_in = {sa ^ sb, fip_pkg::EXP_MAX, 52'd0}; done_in = 1'b1;
                  end else if (a_zero || b_zero) begin
                     res_in = {sa ^ sb, 63'd0}; done_in = 1'b1;
                  end
               end else begin
                  sign_in = sa;
                  mb_in   = {ea != 11'd0, fa};
                  z_in    = 14'sd2046 - $signed({3'b000, (ea == 11'd0) ? 11'd1 : ea});
                  if (a_nan) begin
                     res_in = req.a | fip_pkg::QUIET_BIT; done_in = 1'b1;
                  end else if (a_inf) begin
                     res_in = {sa, 63'd0}; done_in = 1'b1;
                  end else if (a_zero) begin
                     res_in = {sa, fip_pkg::EXP_MAX, 52'd0}; done_in = 1'b1;
                  end
               end
            end
         end
         // accumulate partial products
         fip_pkg::F_MUL: begin
            p_in   = p_ff + partial_sh;
            cnt_in = cnt_ff + 6'd1;
         end
         // left-justify a subnormal divisor
         fip_pkg::F_DNORM: begin
            if (!mb_ff[52]) begin
               mb_in = {mb_ff[51:0], 1'b0};
               z_in  = z_ff + 14'sd1;
            end else begin
               rem_in = {2'b01, 52'd0};
            end
         end
         // one quotient bit per cycle, 56 bits total
         fip_pkg::F_DIV: begin
            rem_in = {rem_sub[52:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd55)
               p_in = {p_ff[54:0], qbit, 49'd0, rem_sub != 54'd0};
            else
               p_in = {p_ff[104:0], qbit};
         end
         fip_pkg::F_NORM: begin
            if (!p_ff[105]) begin
               p_in = {p_ff[104:0], 1'b0};
               z_in = z_ff - 14'sd1;
            end
         end
         // denormalize toward the subnormal range, keeping a sticky bit
         fip_pkg::F_ALIGN: begin
            if (z_ff < -14'sd110) begin
               p_in = {105'd0, |p_ff};
               z_in = 14'sd1;
            end else if (z_ff < 14'sd1) begin
               p_in = {1'b0, p_ff[105:2], p_ff[1] | p_ff[0]};
               z_in = z_ff + 14'sd1;
            end
         end
         fip_pkg::F_ROUND: begin
            done_in = 1'b1;
            if (z_rnd >= 14'sd2047)
               res_in = {sign_ff, fip_pkg::EXP_MAX, 52'd0};
            else
               res_in = {sign_ff, mant_out[52] ? z_rnd[10:0] : 11'd0, mant_out[51:0]};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fip_pkg::F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sign_ff <= sign_in;
      z_ff    <= z_in;
      p_ff    <= p_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.bits = res_ff;

endmodule

### rtl/fip_ctrl.sv
// Sequencer for float_integer_power: special cases, repeated multiply, final reciprocal.
// Depends on fip_pkg; drives fip_fpu through fpu_req_type / fpu_rsp_type.
module fip_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [63:0]           base_bits,
   input  logic [15:0]           power_exponent,
   input  fip_pkg::fpu_rsp_type  fpu_rsp,
   output fip_pkg::fpu_req_type  fpu_req,
   output logic                  busy,
   output logic                  rsp_valid,
   output logic [63:0]           rsp_bits
);

   fip_pkg::ctrl_state_type state_ff, state_in;
   logic [63:0]                   acc_ff, acc_in;
   logic [63:0]                   base_ff, base_in;
   logic [fip_pkg::EXP_BITS-1:0]  cnt_ff, cnt_in;
   logic                          neg_ff, neg_in;
   logic                          issue_ff, issue_in;
   logic                          div_ff, div_in;
   logic                          valid_ff, valid_in;
   logic [63:0]                   out_ff, out_in;

   logic [fip_pkg::EXP_BITS-1:0]  e_val, mag;
   logic                          e_neg, base_zero, accept, special, stop;

   always_comb begin
      e_val     = power_exponent[fip_pkg::EXP_BITS-1:0];
      e_neg     = e_val[fip_pkg::EXP_BITS-1];
      mag       = e_neg ? (~e_val + 1'b1) : e_val;
      base_zero = (base_bits[62:0] == 63'd0);
      accept    = start && (state_ff == fip_pkg::C_IDLE);
      special   = (e_val == '0) || (e_val == fip_pkg::EXP_BITS'(1)) || (base_zero && !e_neg);
      // product unchanged or count exhausted
      stop      = (fpu_rsp.bits == acc_ff) || (cnt_ff == fip_pkg::EXP_BITS'(1));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fip_pkg::C_IDLE: if (accept && !special) state_in = fip_pkg::C_MUL;
         fip_pkg::C_MUL: begin
            if (fpu_rsp.done && stop)
               state_in = neg_ff ? fip_pkg::C_DIV : fip_pkg::C_IDLE;
         end
         fip_pkg::C_DIV: if (fpu_rsp.done) state_in = fip_pkg::C_IDLE;
         default:        state_in = fip_pkg::C_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      acc_in   = acc_ff;
      base_in  = base_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      issue_in = 1'b0;
      div_in   = div_ff;
      valid_in = 1'b0;
      out_in   = out_ff;
      case (state_ff)
         fip_pkg::C_IDLE: begin
            if (accept) begin
               base_in = base_bits;
               neg_in  = e_neg;
               cnt_in  = mag;
               acc_in  = fip_pkg::ONE_BITS;
               if (e_val == '0) begin
                  valid_in = 1'b1;
                  out_in   = base_zero ? fip_pkg::NEG_ONE_BITS : fip_pkg::ONE_BITS;
               end else if (e_val == fip_pkg::EXP_BITS'(1)) begin
                  valid_in = 1'b1;
                  out_in   = base_bits;
               end else if (base_zero && !e_neg) begin
                  valid_in = 1'b1;
                  out_in   = 64'd0;
               end else begin
                  issue_in = 1'b1;
                  div_in   = 1'b0;
               end
            end
         end
         fip_pkg::C_MUL: begin
            if (fpu_rsp.done) begin
               if (fpu_rsp.bits != acc_ff)
                  acc_in = fpu_rsp.bits;
               cnt_in = cnt_ff - 1'b1;
               if (stop) begin
                  if (neg_ff) begin
                     // reciprocal of the final product
                     issue_in = 1'b1;
                     div_in   = 1'b1;
                  end else begin
                     valid_in = 1'b1;
                     out_in   = (fpu_rsp.bits == acc_ff) ? acc_ff : fpu_rsp.bits;
                  end
               end else begin
                  issue_in = 1'b1;
               end
            end
         end
         fip_pkg::C_DIV: begin
            if (fpu_rsp.done) begin
               valid_in = 1'b1;
               out_in   = fpu_rsp.bits;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fip_pkg::C_IDLE;
         issue_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      base_ff <= base_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      div_ff  <= div_in;
      out_ff  <= out_in;
   end

   assign fpu_req.start  = issue_ff;
   assign fpu_req.is_div = div_ff;
   assign fpu_req.a      = acc_ff;
   assign fpu_req.b      = base_ff;
   assign busy           = (state_ff != fip_pkg::C_IDLE);
   assign rsp_valid      = valid_ff;
   assign rsp_bits       = out_ff;

endmodule

### rtl/fip_checker.sv
// Port-level checks for float_integer_power, attached by bind.
// Depends only on the top level's ports.
module fip_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [63:0] rsp_result_bits
);

   // a result is only shown once the block has gone idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");

   // an accepted item either starts work or answers at once
   a_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid) else $error("item dropped");

   // work only begins on an accepted item
   a_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start)) else $error("busy without an item");

   // finishing work always delivers a result
   a_finish: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid) else $error("work ended without result");

   // a shown result carries known bits
   a_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_result_bits)) else $error("unknown result bits");

endmodule

bind float_integer_power fip_checker u_fip_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_result_bits (rsp_result_bits)
);

### tb/tb.sv
// Self-checking testbench for float_integer_power: double base to a signed integer power.
// Depends on the float_integer_power RTL; predicts every result with the simulator's
// IEEE double arithmetic and compares it bit for bit.
module tb;

   localparam int EXPW = 16;

   typedef struct {
      logic [63:0] base;
      logic [15:0] expo;
      bit          drain;   // hold off until every expected result is back
   } power_item_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [63:0] req_base_bits;
   logic [15:0] req_power_exponent;
   logic        rsp_valid;
   logic [63:0] rsp_result_bits;

   power_item_type pending_items[$];
   logic [63:0]    expected_powers[$];
   int             fail_count = 0;
   int             accepted_count = 0;
   int             checked_count = 0;
   bit             took = 0;
   int             gap_left = 0;

   float_integer_power i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_base_bits(req_base_bits), .req_power_exponent(req_power_exponent),
      .rsp_valid(rsp_valid), .rsp_result_bits(rsp_result_bits)
   );

   // clock
   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   // expected power: special cases first, then repeated multiply and reciprocal
   function automatic logic [63:0] power_of(logic [63:0] b, logic [15:0] e);
      real         base_r;
      real         acc;
      real         nxt;
      int          mag;
      bit          neg;
      bit          zero_base;
      begin
         neg       = e[EXPW-1];
         mag       = neg ? (65536 - int'(e)) : int'(e);
         zero_base = (b[62:0] == 63'd0);
         base_r    = $bitstoreal(b);
         if (e == 16'd0) return zero_base ? 64'hBFF0_0000_0000_0000 : 64'h3FF0_0000_0000_0000;
         if (e == 16'd1) return b;
         if (zero_base && !neg) return 64'd0;
         acc = 1.0;
         for (int i = 0; i < mag; i++) begin
            nxt = acc * base_r;
            if ($realtobits(nxt) == $realtobits(acc)) break;
            acc = nxt;
         end
         if (neg) acc = 1.0 / acc;
         return $realtobits(acc);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      begin
         fail_count++;
         $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
      end
   endtask

   task automatic add_item(input logic [63:0] b, input logic [15:0] e, input bit d = 0);
      power_item_type it;
      begin
         it.base = b; it.expo = e; it.drain = d;
         pending_items.push_back(it);
      end
   endtask

   // base close to 1.0 with random mantissa, either sign
   function automatic logic [63:0] near_one();
      logic [63:0] v;
      begin
         v        = {$urandom, $urandom};
         v[62:52] = $urandom_range(0, 1) ? 11'h3FF : 11'h3FE;
         return v;
      end
   endfunction

   // driver: new item or idle at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (pending_items.size() > 15 && $urandom_range(0, 5) == 0) begin
            gap_left <= $urandom_range(0, 6);
            start    <= 1'b0;
         end else if (pending_items.size() > 0 &&
                      !(pending_items[0].drain && expected_powers.size() > 0)) begin
            power_item_type it;
            it = pending_items.pop_front();
            req_base_bits      <= it.base;
            req_power_exponent <= it.expo;
            start              <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: accept items and check results at the rising edge
   always @(posedge clock) begin
      took <= start && !busy && !reset;
      if (!reset) begin
         if (start && !busy) begin
            expected_powers.push_back(power_of(req_base_bits, req_power_exponent));
            accepted_count++;
         end
         if (rsp_valid) begin
            if (expected_powers.size() == 0) begin
               report_mismatch("unexpected result", rsp_result_bits, 64'd0);
            end else begin
               logic [63:0] want;
               want = expected_powers.pop_front();
               checked_count++;
               if (rsp_result_bits !== want)
                  report_mismatch("result_bits", rsp_result_bits, want);
            end
         end
      end
   end

   // run limit
   initial begin
      #(8 * 40_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // stimulus and end of run
   initial begin
      logic [15:0] e;
      reset = 1'b1;
      start = 1'b0;
      req_base_bits = 64'd0;
      req_power_exponent = 16'd0;

      // directed: special cases and field extremes
      add_item(64'h0000_0000_0000_0000, 16'd0);
      add_item(64'h8000_0000_0000_0000, 16'd0);
      add_item(64'h7FF8_0000_0000_0001, 16'd0);
      add_item(64'hFFFF_FFFF_FFFF_FFFF, 16'd1);
      add_item(64'h8000_0000_0000_0000, 16'd1);
      add_item(64'h0000_0000_0000_0000, 16'd7);
      add_item(64'h8000_0000_0000_0000, 16'd32767);
      add_item(64'h0000_0000_0000_0000, 16'hFFFF);
      add_item(64'h8000_0000_0000_0000, 16'hFFFD, 1);
      add_item(64'h7FF8_0000_0000_0000, 16'd3);
      add_item(64'h7FF0_0000_0000_0000, 16'hFFFE);
      add_item(64'hFFF0_0000_0000_0000, 16'd3);
      add_item(64'h3FF0_0000_0000_0000, 16'h8000);
      add_item(64'h3FF0_0000_0000_0001, 16'h8000);
      add_item(64'h4000_0000_0000_0000, 16'd32767);
      add_item(64'hBFF0_0000_0000_0000, 16'd32767);
      add_item(64'h0000_0000_0000_0001, 16'd2);
      add_item(64'h000F_FFFF_FFFF_FFFF, 16'hFFFF);
      add_item(64'h3FE0_0000_0000_0000, 16'd2000, 1);
      add_item(64'h7FEF_FFFF_FFFF_FFFF, 16'd2);
      add_item(64'h4008_0000_0000_0000, 16'hFFFB);

      // random: mostly small exponents, some full-width ones
      for (int n = 0; n < 80; n++) begin
         logic [63:0] b;
         case ($urandom_range(0, 3))
            0:       b = {$urandom, $urandom};
            1:       b = near_one();
            2:       b = {1'($urandom_range(0, 1)), 11'($urandom_range(1000, 1050)),
                          20'($urandom), 32'($urandom)};
            default: b = {$urandom, $urandom} & 64'h800F_FFFF_FFFF_FFFF;
         endcase
         if ($urandom_range(0, 9) == 0 && b[62:52] != 11'h3FF && b[62:52] != 11'h3FE)
            e = 16'($urandom);
         else begin
            e = 16'($urandom_range(0, 40));
            if ($urandom_range(0, 1)) e = -e;
         end
         add_item(b, e, n == 40);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (pending_items.size() == 0);
      @(posedge clock);
      wait (!start && expected_powers.size() == 0);
      repeat (400) @(posedge clock);

      $display("Ran %0d powers (%0d results checked): zero, NaN, infinite, subnormal bases,",
               accepted_count, checked_count);
      $display("zero, one, negative and full-range exponents.");
      if (fail_count == 0 && expected_powers.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
